// ----- hw/rtl/blocked_port_table_with_hit_counts_macros.svh -----
// Assertion macros for the checker file of the blocked-port table.
`ifndef BLOCKED_PORT_TABLE_WITH_HIT_COUNTS_MACROS_SVH
`define BLOCKED_PORT_TABLE_WITH_HIT_COUNTS_MACROS_SVH

// Condition holds in the cycle after the trigger.
`define BPT_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("bpt: next-cycle check failed");

// Condition holds in the same cycle as the trigger.
`define BPT_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("bpt: same-cycle check failed");

`endif

// ----- hw/rtl/bpt_pkg.sv -----
// Types, codes and helpers for the blocked-port rule table.
package bpt_pkg;

  localparam int ENTRIES_DEFAULT    = 64;
  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int KEY_BITS           = 18;
  localparam int OUT_COUNT_BITS     = 32;

  // Command selector codes
  localparam logic [2:0] FUNC_CHECK  = 3'd0;
  localparam logic [2:0] FUNC_INSERT = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_QUERY  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Operations carried by the token that walks the cell chain
  localparam logic [2:0] TOK_CHECK  = 3'd0;
  localparam logic [2:0] TOK_FIND   = 3'd1;
  localparam logic [2:0] TOK_REMOVE = 3'd2;
  localparam logic [2:0] TOK_QUERY  = 3'd3;
  localparam logic [2:0] TOK_PLACE  = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] port;
    logic        protocol;
    logic        direction;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      blocked;
    logic [OUT_COUNT_BITS-1:0] attempt_count;
  } rsp_t;

  typedef struct packed {
    logic                      active;
    logic [2:0]                op;
    logic [KEY_BITS-1:0]       key;
    logic                      found;
    logic                      free_seen;
    logic [OUT_COUNT_BITS-1:0] count;
  } tok_t;

  // Clamp a count of up to 64 bits to the 32-bit result field.
  function automatic logic [OUT_COUNT_BITS-1:0] sat_count(input logic [63:0] wide);
    logic [OUT_COUNT_BITS-1:0] res;
    if (|wide[63:OUT_COUNT_BITS]) begin
      res = '1;
    end else begin
      res = wide[OUT_COUNT_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/bpt_cell.sv -----
// One table slot: key, valid bit and hit count, acting on the passing token.
module bpt_cell import bpt_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic clr,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic                  valid;
  logic                  valid_next;
  logic [KEY_BITS-1:0]   key;
  logic [KEY_BITS-1:0]   key_next;
  logic [COUNT_BITS-1:0] hits;
  logic [COUNT_BITS-1:0] hits_next;
  tok_t                  tok_next;
  logic                  match;

  assign match = tok_in.active && valid && (key == tok_in.key);

  always_comb begin
    valid_next = valid;
    key_next   = key;
    hits_next  = hits;
    tok_next   = tok_in;
    if (clr) begin
      valid_next = 1'b0;
    end else if (tok_in.active) begin
      unique case (tok_in.op)
        TOK_CHECK: begin
          if (match) begin
            tok_next.found = 1'b1;
            if (hits != {COUNT_BITS{1'b1}}) begin
              hits_next = hits + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
          end
        end
        TOK_REMOVE: begin
          if (match) begin
            tok_next.found = 1'b1;
            valid_next     = 1'b0;
          end
        end
        TOK_QUERY: begin
          if (match) begin
            tok_next.found = 1'b1;
            tok_next.count = sat_count(64'(hits));
          end
        end
        TOK_FIND: begin
          if (match) begin
            tok_next.found = 1'b1;
          end
          if (!valid) begin
            tok_next.free_seen = 1'b1;
          end
        end
        TOK_PLACE: begin
          // claim the first free slot the token meets
          if (!valid && !tok_in.found) begin
            tok_next.found = 1'b1;
            valid_next     = 1'b1;
            key_next       = tok_in.key;
            hits_next      = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      valid          <= valid_next;
      tok_out.active <= tok_next.active;
    end
    key               <= key_next;
    hits              <= hits_next;
    tok_out.op        <= tok_next.op;
    tok_out.key       <= tok_next.key;
    tok_out.found     <= tok_next.found;
    tok_out.free_seen <= tok_next.free_seen;
    tok_out.count     <= tok_next.count;
  end

endmodule

// ----- hw/rtl/blocked_port_table_with_hit_counts.sv -----
// Top level of the blocked-port rule table: command control and the slot chain.
//
//   channel   direction  handshake                      payload
//   command   in         start, accepted when !busy     cmd (cmd_t)
//   result    out        done, one-cycle strobe          rsp (rsp_t)
//
// Check, remove, query and a refused insert walk the chain once: a token
// walks the chain one slot a cycle. An insert that adds a key walks it
// twice, once to look for the key and once to claim the lowest free slot.
// Clear and unused selectors answer in the next cycle.
// busy drops in the cycle of the result strobe; synchronous reset empties the
// table. The receiver cannot stall; each result is shown for one cycle.
module blocked_port_table_with_hit_counts import bpt_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  tok_t chain [ENTRIES+1];
  tok_t head;
  tok_t head_next;
  tok_t tail;
  logic busy_next;
  logic done_next;
  rsp_t rsp_next;
  logic accept;
  logic clr;

  assign accept = start && !busy;
  assign clr    = accept && (cmd.func == FUNC_CLEAR);
  assign tail   = chain[ENTRIES];

  always_comb begin
    head_next           = head;
    head_next.active    = 1'b0;
    busy_next           = busy;
    done_next           = 1'b0;
    rsp_next            = '0;
    if (accept) begin
      head_next.key       = {cmd.port, cmd.protocol, cmd.direction};
      head_next.found     = 1'b0;
      head_next.free_seen = 1'b0;
      head_next.count     = '0;
      unique case (cmd.func)
        FUNC_CHECK: begin
          head_next.active = 1'b1;
          head_next.op     = TOK_CHECK;
          busy_next        = 1'b1;
        end
        FUNC_INSERT: begin
          head_next.active = 1'b1;
          head_next.op     = TOK_FIND;
          busy_next        = 1'b1;
        end
        FUNC_REMOVE: begin
          head_next.active = 1'b1;
          head_next.op     = TOK_REMOVE;
          busy_next        = 1'b1;
        end
        FUNC_QUERY: begin
          head_next.active = 1'b1;
          head_next.op     = TOK_QUERY;
          busy_next        = 1'b1;
        end
        default: begin
          // clear and unused selectors answer at once with all zeros
          done_next = 1'b1;
        end
      endcase
    end else if (tail.active) begin
      done_next = 1'b1;
      busy_next = 1'b0;
      unique case (tail.op)
        TOK_CHECK: begin
          rsp_next.blocked = tail.found;
        end
        TOK_FIND: begin
          if (tail.found) begin
            rsp_next.status = ST_DUP;
          end else if (!tail.free_seen) begin
            rsp_next.status = ST_FULL;
          end else begin
            // relaunch to claim the lowest free slot
            done_next           = 1'b0;
            busy_next           = 1'b1;
            head_next.active    = 1'b1;
            head_next.op        = TOK_PLACE;
            head_next.key       = tail.key;
            head_next.found     = 1'b0;
            head_next.free_seen = 1'b0;
            head_next.count     = '0;
          end
        end
        TOK_REMOVE: begin
          if (!tail.found) begin
            rsp_next.status = ST_NOTFOUND;
          end
        end
        TOK_QUERY: begin
          if (tail.found) begin
            rsp_next.attempt_count = tail.count;
          end else begin
            rsp_next.status = ST_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      head.active <= 1'b0;
    end else begin
      busy        <= busy_next;
      done        <= done_next;
      head.active <= head_next.active;
    end
    rsp            <= rsp_next;
    head.op        <= head_next.op;
    head.key       <= head_next.key;
    head.found     <= head_next.found;
    head.free_seen <= head_next.free_seen;
    head.count     <= head_next.count;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bpt_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .clr    (clr),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

endmodule

// ----- hw/rtl/bpt_checker.sv -----
// Port-level assertions for the blocked-port table, bound to the top level.
`include "blocked_port_table_with_hit_counts_macros.svh"

module bpt_checker import bpt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input rsp_t rsp
);

  logic walk_start;
  logic quick_start;
  logic rsp_plain;
  logic walk_began;
  logic quick_answer;
  logic blocked_shape;

  assign walk_start    = start && !busy && (cmd.func < FUNC_CLEAR);
  assign quick_start   = start && !busy && (cmd.func >= FUNC_CLEAR);
  assign rsp_plain     = (rsp.status == ST_OK) && (rsp.attempt_count == '0);
  assign walk_began    = busy && !done;
  assign quick_answer  = done && !busy && rsp_plain && !rsp.blocked;
  assign blocked_shape = done && rsp.blocked;

  `BPT_ASSERT_NEXT(a_walk_sets_busy, clk, rst, walk_start, walk_began)
  `BPT_ASSERT_NEXT(a_quick_answer, clk, rst, quick_start, quick_answer)
  `BPT_ASSERT_SAME(a_busy_ends_done, clk, rst, $fell(busy), done)
  `BPT_ASSERT_SAME(a_blocked_ok, clk, rst, blocked_shape, rsp_plain)

endmodule

bind blocked_port_table_with_hit_counts bpt_checker u_bpt_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .cmd  (cmd),
  .done (done),
  .rsp  (rsp)
);

// ----- bench/blocked_port_table_with_hit_counts_test.sv -----
// Self-checking bench for the blocked-port rule table: directed and random commands.
module blocked_port_table_with_hit_counts_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpt_pkg::*;

  localparam int ENTRIES       = ENTRIES_DEFAULT;
  localparam int COUNT_BITS    = COUNT_BITS_DEFAULT;
  localparam int POOL_SIZE     = 128;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int PRINT_LIMIT   = 40;
  localparam logic [2:0] FUNC_UNUSED_MIN = FUNC_CLEAR + 3'd1;
  localparam logic [2:0] FUNC_UNUSED_MAX = 3'd7;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  blocked_port_table_with_hit_counts #(
    .ENTRIES(ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .rsp(rsp)
  );

  // Shadow copy of the rule slots
  logic                  rule_valid [ENTRIES] = '{default: 1'b0};
  logic [KEY_BITS-1:0]   rule_key   [ENTRIES];
  logic [COUNT_BITS-1:0] rule_hits  [ENTRIES];

  logic [KEY_BITS-1:0] rule_pool [POOL_SIZE];
  rsp_t due_answers [$];

  bit gaps_on = 1'b1;
  int n_sent = 0;
  int n_answered = 0;
  int n_errors = 0;
  int n_hits = 0;
  int n_dup = 0;
  int n_full = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic cmd_t make_cmd(input logic [2:0] f, input logic [KEY_BITS-1:0] k);
    cmd_t c;
    c.func = f;
    {c.port, c.protocol, c.direction} = k;
    return c;
  endfunction

  // Apply one command to the shadow slots and return the answer it should get.
  function automatic rsp_t apply_rule_op(input cmd_t c);
    rsp_t r;
    logic [KEY_BITS-1:0] k;
    logic [63:0] wide;
    int hit;
    int free_idx;
    r = '0;
    k = {c.port, c.protocol, c.direction};
    hit = -1;
    free_idx = -1;
    // walk downward so both end on the lowest index
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (rule_valid[i] && rule_key[i] == k) hit = i;
      if (!rule_valid[i]) free_idx = i;
    end
    case (c.func)
      FUNC_CHECK: begin
        if (hit >= 0) begin
          r.blocked = 1'b1;
          n_hits++;
          if (rule_hits[hit] != '1) rule_hits[hit] = rule_hits[hit] + 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_DUP;
          n_dup++;
        end else if (free_idx < 0) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          rule_valid[free_idx] = 1'b1;
          rule_key[free_idx] = k;
          rule_hits[free_idx] = '0;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) rule_valid[hit] = 1'b0;
        else r.status = ST_NOTFOUND;
      end
      FUNC_QUERY: begin
        if (hit >= 0) begin
          wide = 64'(rule_hits[hit]);
          r.attempt_count = (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_COUNT_BITS-1:0];
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      FUNC_CLEAR: begin
        foreach (rule_valid[i]) rule_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict on every accepted item, then compare any result shown this cycle.
  always @(posedge clk) begin : result_monitor
    rsp_t want;
    if (!rst) begin
      if (start && !busy) due_answers.push_back(apply_rule_op(cmd));
      if (done) begin
        if (due_answers.size() == 0) begin
          report_mismatch("result strobe with no item outstanding");
        end else begin
          want = due_answers.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      n_answered, rsp.status, want.status));
          if (rsp.blocked !== want.blocked)
            report_mismatch($sformatf("result %0d blocked %0b, want %0b",
                                      n_answered, rsp.blocked, want.blocked));
          if (rsp.attempt_count !== want.attempt_count)
            report_mismatch($sformatf("result %0d attempt_count %0d, want %0d",
                                      n_answered, rsp.attempt_count, want.attempt_count));
        end
        n_answered++;
      end
    end
  end

  // Call at a rising edge; returns at the edge that accepts the item, or later after a random idle gap.
  task automatic send_cmd(input cmd_t c);
    int r;
    int gap;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(99);
      if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(3, 1);
      else if (r < 97) gap = $urandom_range(10, 4);
      else gap = $urandom_range(60, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every accepted item has been answered or the wait limit runs out.
  task automatic wait_answers(input int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    while (n_answered < n_sent && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic send_random(input int pool_n, input int ins_pct, input int rem_pct,
                             input int chk_pct, input int qry_pct);
    int r;
    logic [2:0] f;
    logic [KEY_BITS-1:0] k;
    r = $urandom_range(99);
    if (r < ins_pct) f = FUNC_INSERT;
    else if (r < ins_pct + rem_pct) f = FUNC_REMOVE;
    else if (r < ins_pct + rem_pct + chk_pct) f = FUNC_CHECK;
    else if (r < ins_pct + rem_pct + chk_pct + qry_pct) f = FUNC_QUERY;
    else if ($urandom_range(3) == 0) f = FUNC_CLEAR;
    else f = 3'($urandom_range(FUNC_UNUSED_MAX, FUNC_UNUSED_MIN));
    if ($urandom_range(9) != 0) k = rule_pool[$urandom_range(pool_n - 1)];
    else k = KEY_BITS'($urandom);
    send_cmd(make_cmd(f, k));
  endtask

  task automatic test_directed_ops();
    logic [KEY_BITS-1:0] k_low;
    logic [KEY_BITS-1:0] k_high;
    logic [KEY_BITS-1:0] k_miss;
    k_low  = '0;
    k_high = '1;
    k_miss = {16'h8001, 1'b1, 1'b0};
    send_cmd(make_cmd(FUNC_INSERT, k_low));
    send_cmd(make_cmd(FUNC_INSERT, k_high));
    send_cmd(make_cmd(FUNC_INSERT, k_low));
    send_cmd(make_cmd(FUNC_CHECK, k_low));
    send_cmd(make_cmd(FUNC_CHECK, k_low));
    send_cmd(make_cmd(FUNC_QUERY, k_low));
    send_cmd(make_cmd(FUNC_QUERY, k_high));
    send_cmd(make_cmd(FUNC_CHECK, k_miss));
    send_cmd(make_cmd(FUNC_QUERY, k_miss));
    send_cmd(make_cmd(FUNC_REMOVE, k_miss));
    send_cmd(make_cmd(FUNC_REMOVE, k_high));
    send_cmd(make_cmd(FUNC_QUERY, k_high));
    send_cmd(make_cmd(FUNC_CHECK, k_high));
    // keys that differ only in the protocol bit
    send_cmd(make_cmd(FUNC_INSERT, {16'd5, 1'b0, 1'b1}));
    send_cmd(make_cmd(FUNC_CHECK, {16'd5, 1'b1, 1'b1}));
    for (int f = FUNC_UNUSED_MIN; f <= FUNC_UNUSED_MAX; f++) begin
      send_cmd(make_cmd(3'(f), k_low));
    end
    send_cmd(make_cmd(FUNC_QUERY, k_low));
    send_cmd(make_cmd(FUNC_CLEAR, k_low));
    send_cmd(make_cmd(FUNC_QUERY, k_low));
    send_cmd(make_cmd(FUNC_INSERT, k_low));
    send_cmd(make_cmd(FUNC_QUERY, k_low));
  endtask

  // Few keys, so checks and queries hit often and counts build up.
  task automatic test_hit_counting();
    gaps_on = 1'b0;
    for (int i = 0; i < 300; i++) begin
      if (i == 100) gaps_on = 1'b1;
      send_random(10, 25, 15, 38, 18);
    end
  endtask

  task automatic test_table_full();
    logic [KEY_BITS-1:0] held [ENTRIES + 8];
    send_cmd(make_cmd(FUNC_CLEAR, '0));
    foreach (held[i]) begin
      held[i] = KEY_BITS'($urandom);
      send_cmd(make_cmd(FUNC_INSERT, held[i]));
    end
    // a present key still reports duplicate on a full table
    send_cmd(make_cmd(FUNC_INSERT, held[3]));
    send_cmd(make_cmd(FUNC_CHECK, held[ENTRIES - 1]));
    send_cmd(make_cmd(FUNC_QUERY, held[ENTRIES - 1]));
    send_cmd(make_cmd(FUNC_REMOVE, held[10]));
    send_cmd(make_cmd(FUNC_INSERT, held[ENTRIES + 1]));
    send_cmd(make_cmd(FUNC_INSERT, held[ENTRIES + 2]));
    send_cmd(make_cmd(FUNC_QUERY, held[10]));
    send_cmd(make_cmd(FUNC_QUERY, held[ENTRIES + 1]));
  endtask

  // More keys than slots: the table fills, drains and refills.
  task automatic test_churn();
    send_cmd(make_cmd(FUNC_CLEAR, '0));
    for (int i = 0; i < 300; i++) begin
      if (i % 60 == 59) wait_answers(DRAIN_LIMIT);
      send_random(100, 45, 14, 20, 19);
    end
  endtask

  task automatic test_raw_fields();
    cmd_t c;
    for (int i = 0; i < 150; i++) begin
      c.func      = 3'($urandom_range(FUNC_UNUSED_MAX));
      c.port      = 16'($urandom);
      c.protocol  = 1'($urandom);
      c.direction = 1'($urandom);
      if ($urandom_range(1) == 0) {c.port, c.protocol, c.direction} = rule_pool[$urandom_range(19)];
      send_cmd(c);
    end
  endtask

  initial begin : run
    rule_pool[0] = '0;
    rule_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) rule_pool[i] = KEY_BITS'($urandom);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_hit_counting();
    test_table_full();
    test_churn();
    test_raw_fields();
    wait_answers(DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_answers.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", due_answers.size()));
    end
    $display("sent %0d commands, checked %0d results, %0d mismatches", n_sent, n_answered,
             n_errors);
    $display("seen %0d lookup hits, %0d duplicate inserts, %0d inserts refused when full",
             n_hits, n_dup, n_full);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
